[design/dirb_pkg.sv]
`timescale 1ns / 1ps

package dirb_pkg;

    // Stream and field sizes
    localparam int MESH_W    = 16;
    localparam int FDI_W     = 32;
    localparam int BUCKET_W  = 2;
    localparam int POS_W     = 16;
    localparam int LEN_W     = 17;
    localparam int CTR_W     = 17;
    localparam int OFFSET_W  = 19;
    localparam int FBN_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;
    localparam int S_DATA_W  = 56;
    localparam int M_DATA_W  = 72;

    // Output queue sizing; an item may push two words
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;
    localparam logic [QCNT_W-1:0] QUEUE_ROOM_MAX = QCNT_W'(QUEUE_DEPTH - 2);

    // Saturation limits and reset values
    localparam logic [POS_W-1:0]    POS_CAP       = 16'hFFFF;
    localparam logic [LEN_W-1:0]    LEN_CAP       = 17'd65536;
    localparam logic [CTR_W-1:0]    CTR_CAP       = 17'h1FFFF;
    localparam logic [BUCKET_W:0]   BUCKET_LIMIT  = 3'd4;
    localparam logic [FDI_W-1:0]    MAX_DRAW_RST  = 32'd65536;
    localparam logic [FBN_W-1:0]    FIRST_NUM_RST = 16'd0;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DRAW_ITEMS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_BATCH_NUMBER = 2'd1;

    // One batch record
    typedef struct packed {
        logic [POS_W-1:0]    begin_index;
        logic [LEN_W-1:0]    item_count;
        logic [OFFSET_W-1:0] visible_count_offset;
        logic [MESH_W-1:0]   batch_mesh;
        logic [BUCKET_W-1:0] batch_bucket;
        logic                batch_double_sided;
        logic                final_batch;
    } dirb_batch_t;

    // Records pushed by one draw item
    typedef struct packed {
        logic push_first;
        logic push_second;
    } dirb_push_t;

endpackage

[design/dirb_run_tracker.sv]
`timescale 1ns / 1ps

module dirb_run_tracker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             item_accept,
    input  logic                             mesh_present,
    input  logic [dirb_pkg::MESH_W-1:0]      mesh_id,
    input  logic [dirb_pkg::FDI_W-1:0]       frame_data_index,
    input  logic [dirb_pkg::BUCKET_W-1:0]    bucket,
    input  logic                             double_sided,
    input  logic                             last_item,
    input  logic                             cfg_we,
    input  logic [dirb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dirb_pkg::CFG_W-1:0]       cfg_wdata,
    output dirb_pkg::dirb_push_t             push,
    output dirb_pkg::dirb_batch_t            rec_first,
    output dirb_pkg::dirb_batch_t            rec_second
);
    import dirb_pkg::*;

    logic [FDI_W-1:0]    max_draw_reg,  max_draw_next;
    logic [FBN_W-1:0]    first_num_reg, first_num_next;
    logic [POS_W-1:0]    pos_reg,       pos_next;
    logic                open_reg,      open_next;
    logic [MESH_W-1:0]   mesh_reg,      mesh_next;
    logic [BUCKET_W-1:0] bucket_reg,    bucket_next;
    logic                two_reg,       two_next;
    logic [POS_W-1:0]    begin_reg,     begin_next;
    logic [LEN_W-1:0]    len_reg,       len_next;
    logic [CTR_W-1:0]    ctr_reg,       ctr_next;

    logic             item_valid;
    logic             same_key;
    logic             emit_first;
    logic             emit_second;
    logic [CTR_W-1:0] ctr_mid;
    logic             open_mid;
    logic [POS_W-1:0] begin_mid;
    logic [LEN_W-1:0] len_mid;
    logic [MESH_W-1:0]   mesh_mid;
    logic [BUCKET_W-1:0] bucket_mid;
    logic                two_mid;

    // Classify the item and find run breaks
    assign item_valid = mesh_present && (frame_data_index < max_draw_reg)
                        && ({1'b0, bucket} < BUCKET_LIMIT);
    assign same_key   = item_valid && (mesh_reg == mesh_id) && (bucket_reg == bucket)
                        && (two_reg == double_sided);
    assign emit_first = open_reg && !same_key;

    // Run state after the item is folded in, before the last-item flush
    always_comb begin
        ctr_mid    = (emit_first && ctr_reg < CTR_CAP) ? ctr_reg + 1'b1 : ctr_reg;
        open_mid   = item_valid;
        begin_mid  = begin_reg;
        len_mid    = len_reg;
        mesh_mid   = mesh_reg;
        bucket_mid = bucket_reg;
        two_mid    = two_reg;
        if (item_valid) begin
            if (open_reg && same_key) begin
                if (len_reg < LEN_CAP) begin
                    len_mid = len_reg + 1'b1;
                end
            end else begin
                begin_mid  = pos_reg;
                len_mid    = {{(LEN_W-1){1'b0}}, 1'b1};
                mesh_mid   = mesh_id;
                bucket_mid = bucket;
                two_mid    = double_sided;
            end
        end
    end

    assign emit_second = last_item && open_mid;

    // Build the two candidate records
    always_comb begin
        rec_first.begin_index          = begin_reg;
        rec_first.item_count           = len_reg;
        rec_first.visible_count_offset = {ctr_reg, 2'b00};
        rec_first.batch_mesh           = mesh_reg;
        rec_first.batch_bucket         = bucket_reg;
        rec_first.batch_double_sided   = two_reg;
        rec_first.final_batch          = last_item && !item_valid;

        rec_second.begin_index          = begin_mid;
        rec_second.item_count           = len_mid;
        rec_second.visible_count_offset = {ctr_mid, 2'b00};
        rec_second.batch_mesh           = mesh_mid;
        rec_second.batch_bucket         = bucket_mid;
        rec_second.batch_double_sided   = two_mid;
        rec_second.final_batch          = 1'b1;

        push.push_first  = item_accept && emit_first;
        push.push_second = item_accept && emit_second;
    end

    // Next state: item step, else configuration write
    always_comb begin
        max_draw_next  = max_draw_reg;
        first_num_next = first_num_reg;
        pos_next       = pos_reg;
        open_next      = open_reg;
        mesh_next      = mesh_reg;
        bucket_next    = bucket_reg;
        two_next       = two_reg;
        begin_next     = begin_reg;
        len_next       = len_reg;
        ctr_next       = ctr_reg;
        if (item_accept) begin
            mesh_next   = mesh_mid;
            bucket_next = bucket_mid;
            two_next    = two_mid;
            begin_next  = begin_mid;
            len_next    = len_mid;
            if (last_item) begin
                open_next = 1'b0;
                pos_next  = '0;
                ctr_next  = {1'b0, first_num_reg};
            end else begin
                open_next = open_mid;
                ctr_next  = ctr_mid;
                if (pos_reg < POS_CAP) begin
                    pos_next = pos_reg + 1'b1;
                end
            end
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MAX_DRAW_ITEMS: begin
                    max_draw_next = cfg_wdata;
                end
                REG_FIRST_BATCH_NUMBER: begin
                    first_num_next = cfg_wdata[FBN_W-1:0];
                    if (pos_reg == '0 && !open_reg) begin
                        ctr_next = {1'b0, cfg_wdata[FBN_W-1:0]};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Hold run state and registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_draw_reg  <= MAX_DRAW_RST;
            first_num_reg <= FIRST_NUM_RST;
            pos_reg       <= '0;
            open_reg      <= 1'b0;
            mesh_reg      <= '0;
            bucket_reg    <= '0;
            two_reg       <= 1'b0;
            begin_reg     <= '0;
            len_reg       <= '0;
            ctr_reg       <= {1'b0, FIRST_NUM_RST};
        end else begin
            max_draw_reg  <= max_draw_next;
            first_num_reg <= first_num_next;
            pos_reg       <= pos_next;
            open_reg      <= open_next;
            mesh_reg      <= mesh_next;
            bucket_reg    <= bucket_next;
            two_reg       <= two_next;
            begin_reg     <= begin_next;
            len_reg       <= len_next;
            ctr_reg       <= ctr_next;
        end
    end

endmodule

[design/dirb_out_queue.sv]
`timescale 1ns / 1ps

module dirb_out_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dirb_pkg::dirb_push_t  push,
    input  dirb_pkg::dirb_batch_t rec_first,
    input  dirb_pkg::dirb_batch_t rec_second,
    output logic                  room,
    output logic                  out_valid,
    input  logic                  out_ready,
    output dirb_pkg::dirb_batch_t out_rec
);
    import dirb_pkg::*;

    dirb_batch_t       slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg,  count_next;
    logic              pop;
    logic [1:0]        push_num;
    logic [QPTR_W-1:0] wr_ptr_plus;

    // Room for the two words one item may produce
    assign room      = (count_reg <= QUEUE_ROOM_MAX);
    assign out_valid = (count_reg != '0);
    assign out_rec   = slot_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    assign push_num    = {1'b0, push.push_first} + {1'b0, push.push_second};
    assign wr_ptr_plus = wr_ptr_reg + QPTR_W'(1);

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_num);
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push_num) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store words, the closed run ahead of the flushed one
    always_ff @(posedge aclk) begin
        if (push.push_first) begin
            slot_reg[wr_ptr_reg] <= rec_first;
            if (push.push_second) begin
                slot_reg[wr_ptr_plus] <= rec_second;
            end
        end else if (push.push_second) begin
            slot_reg[wr_ptr_reg] <= rec_second;
        end
    end

endmodule

[design/draw_item_run_batcher_unit.sv]
`timescale 1ns / 1ps

// Draw item run batcher.
// s_ channel carries one draw item per word; s_tlast marks the final item of
// a stream. m_ channel carries one batch record per word; m_tlast marks the
// batch flushed by the final item. Consecutive valid items with the same
// mesh, bucket and double-sided flag form one batch.
// The cfg_ port writes max_draw_items (index 0) and first_batch_number
// (index 1); write only while the block is idle.
// Records are registered in the output queue and offered on m_ from there.
// Throughput: one item per cycle while the queue has room. An item that
// closes one run and flushes another yields two records, which leave one
// after the other from a four-entry output queue.
// s_tready is high while the queue has two free entries, so a stalled
// receiver backs up into the input once three or more words are pending.
// Reset clears the queue and run state and restores the register defaults
// (max_draw_items 65536, first_batch_number 0).
module draw_item_run_batcher_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [0] mesh_present, [16:1] mesh_id, [48:17] frame_data_index,
    // [50:49] bucket, [51] double_sided, [55:52] zero
    input  logic [dirb_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [15:0] begin_index, [32:16] item_count, [51:33] visible_count_offset,
    // [67:52] batch_mesh, [69:68] batch_bucket, [70] batch_double_sided,
    // [71] zero
    output logic [dirb_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [dirb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dirb_pkg::CFG_W-1:0]      cfg_wdata
);
    import dirb_pkg::*;

    logic        item_accept;
    logic        room;
    dirb_push_t  push;
    dirb_batch_t rec_first;
    dirb_batch_t rec_second;
    dirb_batch_t out_rec;

    assign s_tready    = room;
    assign item_accept = s_tvalid && room;

    // Track runs and build records
    dirb_run_tracker u_tracker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .item_accept      (item_accept),
        .mesh_present     (s_tdata[0]),
        .mesh_id          (s_tdata[16:1]),
        .frame_data_index (s_tdata[48:17]),
        .bucket           (s_tdata[50:49]),
        .double_sided     (s_tdata[51]),
        .last_item        (s_tlast),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .push             (push),
        .rec_first        (rec_first),
        .rec_second       (rec_second)
    );

    // Queue records for the receiver
    dirb_out_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .rec_first  (rec_first),
        .rec_second (rec_second),
        .room       (room),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_rec    (out_rec)
    );

    // Pack the output word
    assign m_tdata = {1'b0,
                      out_rec.batch_double_sided,
                      out_rec.batch_bucket,
                      out_rec.batch_mesh,
                      out_rec.visible_count_offset,
                      out_rec.item_count,
                      out_rec.begin_index};
    assign m_tlast = out_rec.final_batch;

endmodule
